@@ rtl/owsf_pkg.sv @@
`timescale 1ns / 1ps

package owsf_pkg;

    localparam int MAX_WIDTH_C  = 1024;
    localparam int MAX_HEIGHT_C = 1024;
    localparam int MAX_SPAN     = 7;
    localparam int HALF_MAX     = (MAX_SPAN - 1) / 2;
    localparam int ORIENT       = 8;
    localparam int SLOT_W       = $clog2(MAX_SPAN);
    localparam int VCNT_W       = $clog2(MAX_SPAN + 1);
    localparam int WCNT_W       = $clog2(MAX_SPAN * MAX_SPAN + 1);
    localparam int PIX_W        = 8;
    localparam int POS_W        = 10;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 3;
    localparam int HALF_W       = 2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [VCNT_W-1:0] vcnt_t;
    typedef vcnt_t [ORIENT-1:0] vcol_t;
    typedef logic [WCNT_W-1:0] wcnt_t;

    typedef struct packed {
        vcol_t vcol;
        pix_t  centre;
    } tap_t;

    // row offset held by a bank, relative to the row whose slot is given
    function automatic logic signed [SLOT_W:0] bank_delta(input logic [SLOT_W-1:0] bank,
                                                          input logic [SLOT_W-1:0] slot);
        int d;
        d = int'(bank) - int'(slot);
        if (d < 0) d = d + MAX_SPAN;
        if (d > HALF_MAX) d = d - MAX_SPAN;
        return (SLOT_W + 1)'(d);
    endfunction

endpackage

@@ rtl/owsf_line_store.sv @@
`timescale 1ns / 1ps

module owsf_line_store
    import owsf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_C
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [SLOT_W-1:0]            wr_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  pix_t                         wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output pix_t [MAX_SPAN-1:0]          rd_data
);

    for (genvar bk = 0; bk < MAX_SPAN; bk++) begin : g_bank
        pix_t mem [MAX_WIDTH];
        pix_t rd_q;

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_bank == SLOT_W'(bk))) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_q <= mem[rd_addr];
            end
        end

        assign rd_data[bk] = rd_q;
    end

endmodule

@@ rtl/orientation_window_spread_filter_top.sv @@
`timescale 1ns / 1ps
// A result passes the read, window, decision and output registers before m_tdata.
// Throughput: one item per cycle unless stalled; all seven banks are read on each push.
// A result trails the pixel stream by half_span rows plus half_span pixels; each
// flush item after the frame's last pixel drains one remaining result.
// Reset: registers return to mode 1, half_span 1, 640 x 480; the frame restarts.

module orientation_window_spread_filter_top
    import owsf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_C,
    parameter int MAX_HEIGHT = MAX_HEIGHT_C
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // pixel
    input  logic                 s_tuser,    // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,    // pixel_out, out_row, out_col, zero fill
    output logic                 m_tlast,    // frame_end
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int COLN_W = $clog2(MAX_WIDTH + 1);
    localparam int ROWN_W = $clog2(MAX_HEIGHT + 1);
    localparam int RAS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int XW     = (COLN_W > CFG_W) ? COLN_W : CFG_W;
    localparam int YW     = (ROWN_W > CFG_W) ? ROWN_W : CFG_W;

    // configuration
    logic              mode_reg;
    logic [HALF_W-1:0] half_reg;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic              cfg_pend_reg;
    logic              cfg_fire;
    logic              cfg_hit;

    // derived sizes
    logic [COLN_W-1:0] w_reg, w_next;
    logic [ROWN_W-1:0] ht_reg, ht_next;
    logic [HALF_W-1:0] h_reg, h_next;
    logic [RAS_W-1:0]  total_reg, lagv_reg;
    logic [XW-1:0]     w_x;
    logic [YW-1:0]     ht_x;
    logic [COLN_W-1:0] hlim;

    // raster counters
    logic [RAS_W-1:0]  arrived_reg, arrived_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [RAS_W-1:0]  push_idx_reg, push_idx_next;
    logic [COL_W-1:0]  push_col_reg, push_col_next;
    logic [ROWN_W-1:0] push_row_reg, push_row_next;
    logic [SLOT_W-1:0] push_slot_reg, push_slot_next;
    logic [RAS_W-1:0]  out_idx_reg, out_idx_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROWN_W-1:0] out_row_reg, out_row_next;

    // accept stage
    logic                fire;
    logic                is_pix, pix_ok, flush_ok, full_in;
    logic                a_push, a_emit, a_last, restart;
    logic                wr_en;
    logic [MAX_SPAN-1:0] a_mask;

    // read stage
    logic                b_v_reg, b_emit_reg, b_last_reg;
    logic [MAX_SPAN-1:0] b_mask_reg;
    logic [SLOT_W-1:0]   b_slot_reg, b_fwd_bank_reg;
    logic                b_fwd_v_reg;
    pix_t                b_fwd_pix_reg;
    logic [COL_W-1:0]    b_col_reg;
    logic [ROWN_W-1:0]   b_row_reg;
    pix_t [MAX_SPAN-1:0] rd_data;
    pix_t [MAX_SPAN-1:0] b_data;
    tap_t                b_tap;
    tap_t [MAX_SPAN-1:0] taps_reg;

    // window stage
    logic                c_v_reg, c_last_reg;
    logic [COL_W-1:0]    c_col_reg;
    logic [ROWN_W-1:0]   c_row_reg;
    wcnt_t [ORIENT-1:0]  c_sum;
    logic [COLN_W:0]     c_cv;

    // decision stage
    logic                d_v_reg, d_last_reg;
    logic [COL_W-1:0]    d_col_reg;
    logic [ROWN_W-1:0]   d_row_reg;
    wcnt_t [ORIENT-1:0]  d_sum_reg;
    pix_t                d_centre_reg;
    pix_t                d_res;

    // output register
    logic                m_valid_reg, m_last_reg;
    pix_t                m_pix_reg;
    logic [POS_W-1:0]    m_row_reg, m_col_reg;

    logic out_ready, d_ready, c_ready, b_ready, b_fire;

    assign out_ready = !m_valid_reg || m_tready;
    assign d_ready   = !d_v_reg || out_ready;
    assign c_ready   = !c_v_reg || d_ready;
    assign b_ready   = !b_v_reg || c_ready;
    assign b_fire    = b_v_reg && c_ready;
    assign s_tready  = b_ready && !cfg_pend_reg;
    assign cfg_ready = 1'b1;
    assign fire      = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_fire && ((cfg_index == REG_MODE) || (cfg_index == REG_HALF) ||
                                    (cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b1;
            half_reg     <= HALF_W'(1);
            width_reg    <= CFG_W'(640);
            height_reg   <= CFG_W'(480);
            cfg_pend_reg <= 1'b1;
        end else begin
            cfg_pend_reg <= cfg_hit;
            if (cfg_fire) begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_HALF:   half_reg   <= cfg_data[HALF_W-1:0];
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // saturate sizes and clamp the half span
    always_comb begin
        w_x  = XW'(width_reg);
        ht_x = YW'(height_reg);
        if (w_x == '0) w_x = XW'(1);
        else if (w_x > XW'(MAX_WIDTH)) w_x = XW'(MAX_WIDTH);
        if (ht_x == '0) ht_x = YW'(1);
        else if (ht_x > YW'(MAX_HEIGHT)) ht_x = YW'(MAX_HEIGHT);
        w_next  = COLN_W'(w_x);
        ht_next = ROWN_W'(ht_x);
        hlim    = (w_next - COLN_W'(1)) >> 1;
        h_next  = half_reg;
        if (h_next > HALF_W'(HALF_MAX)) h_next = HALF_W'(HALF_MAX);
        if (COLN_W'(h_next) > hlim) h_next = HALF_W'(hlim);
    end

    always_ff @(posedge aclk) begin
        w_reg     <= w_next;
        ht_reg    <= ht_next;
        h_reg     <= h_next;
        total_reg <= RAS_W'(RAS_W'(w_next) * RAS_W'(ht_next));
        lagv_reg  <= RAS_W'(RAS_W'(w_next) * RAS_W'(h_next));
    end

    assign is_pix   = (s_tuser == CMD_PIXEL);
    assign full_in  = (arrived_reg >= total_reg);
    assign pix_ok   = is_pix && !full_in;
    assign flush_ok = !is_pix && full_in && (out_idx_reg < total_reg);
    assign a_last   = ((out_idx_reg + RAS_W'(1)) == total_reg);

    always_comb begin
        if (pix_ok) begin
            a_push = ({1'b0, arrived_reg} >= ({1'b0, push_idx_reg} + {1'b0, lagv_reg}));
            a_emit = ({1'b0, arrived_reg} >= ({1'b0, out_idx_reg} + {1'b0, lagv_reg}
                                              + (RAS_W + 1)'(h_reg)));
        end else begin
            a_push = flush_ok;
            a_emit = flush_ok;
        end
    end

    assign wr_en   = fire && pix_ok;
    assign restart = cfg_hit || (fire && a_emit && a_last);

    always_comb begin
        arrived_next   = arrived_reg;
        in_col_next    = in_col_reg;
        in_slot_next   = in_slot_reg;
        push_idx_next  = push_idx_reg;
        push_col_next  = push_col_reg;
        push_row_next  = push_row_reg;
        push_slot_next = push_slot_reg;
        out_idx_next   = out_idx_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        if (restart) begin
            arrived_next   = '0;
            in_col_next    = '0;
            in_slot_next   = '0;
            push_idx_next  = '0;
            push_col_next  = '0;
            push_row_next  = '0;
            push_slot_next = '0;
            out_idx_next   = '0;
            out_col_next   = '0;
            out_row_next   = '0;
        end else if (fire) begin
            if (wr_en) begin
                arrived_next = arrived_reg + RAS_W'(1);
                if (COLN_W'(in_col_reg) == w_reg - COLN_W'(1)) begin
                    in_col_next  = '0;
                    in_slot_next = (in_slot_reg == SLOT_W'(MAX_SPAN - 1)) ? '0
                                   : in_slot_reg + SLOT_W'(1);
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            if (a_push) begin
                push_idx_next = push_idx_reg + RAS_W'(1);
                if (COLN_W'(push_col_reg) == w_reg - COLN_W'(1)) begin
                    push_col_next  = '0;
                    push_row_next  = push_row_reg + ROWN_W'(1);
                    push_slot_next = (push_slot_reg == SLOT_W'(MAX_SPAN - 1)) ? '0
                                     : push_slot_reg + SLOT_W'(1);
                end else begin
                    push_col_next = push_col_reg + COL_W'(1);
                end
            end
            if (a_emit) begin
                out_idx_next = out_idx_reg + RAS_W'(1);
                if (COLN_W'(out_col_reg) == w_reg - COLN_W'(1)) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROWN_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arrived_reg   <= '0;
            in_col_reg    <= '0;
            in_slot_reg   <= '0;
            push_idx_reg  <= '0;
            push_col_reg  <= '0;
            push_row_reg  <= '0;
            push_slot_reg <= '0;
            out_idx_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
        end else begin
            arrived_reg   <= arrived_next;
            in_col_reg    <= in_col_next;
            in_slot_reg   <= in_slot_next;
            push_idx_reg  <= push_idx_next;
            push_col_reg  <= push_col_next;
            push_row_reg  <= push_row_next;
            push_slot_reg <= push_slot_next;
            out_idx_reg   <= out_idx_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
        end
    end

    // banks that hold a row of the vertical span, clipped at the frame edges
    always_comb begin
        logic signed [SLOT_W:0] dl;
        logic [ROWN_W:0]        ad;
        for (int bk = 0; bk < MAX_SPAN; bk++) begin
            dl = bank_delta(SLOT_W'(bk), push_slot_reg);
            ad = (dl < 0) ? (ROWN_W + 1)'(-dl) : (ROWN_W + 1)'(dl);
            if (ad > (ROWN_W + 1)'(h_reg)) begin
                a_mask[bk] = 1'b0;
            end else if (dl < 0) begin
                a_mask[bk] = ({1'b0, push_row_reg} >= ad);
            end else begin
                a_mask[bk] = (({1'b0, push_row_reg} + ad) < {1'b0, ht_reg});
            end
        end
    end

    owsf_line_store #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_lines (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_bank (in_slot_reg),
        .wr_addr (in_col_reg),
        .wr_data (s_tdata),
        .rd_en   (fire && a_push),
        .rd_addr (push_col_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b_ready) b_v_reg <= fire && a_push;
            if (c_ready) c_v_reg <= b_fire && b_emit_reg;
            if (d_ready) d_v_reg <= c_v_reg;
            if (out_ready) m_valid_reg <= d_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready) begin
            b_emit_reg     <= a_emit;
            b_last_reg     <= a_last;
            b_mask_reg     <= a_mask;
            b_slot_reg     <= push_slot_reg;
            b_fwd_v_reg    <= wr_en && (in_col_reg == push_col_reg);
            b_fwd_bank_reg <= in_slot_reg;
            b_fwd_pix_reg  <= s_tdata;
            b_col_reg      <= out_col_reg;
            b_row_reg      <= out_row_reg;
        end
    end

    // vertical counts for the entering column, with the same-cycle write forwarded
    always_comb begin
        for (int bk = 0; bk < MAX_SPAN; bk++) begin
            b_data[bk] = (b_fwd_v_reg && (b_fwd_bank_reg == SLOT_W'(bk))) ? b_fwd_pix_reg
                         : rd_data[bk];
        end
        for (int o = 0; o < ORIENT; o++) begin
            b_tap.vcol[o] = '0;
            for (int bk = 0; bk < MAX_SPAN; bk++) begin
                if (b_mask_reg[bk] && (b_data[bk] == pix_t'(1 << o))) begin
                    b_tap.vcol[o] = b_tap.vcol[o] + VCNT_W'(1);
                end
            end
        end
        b_tap.centre = b_data[b_slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            taps_reg <= {taps_reg[MAX_SPAN-2:0], b_tap};
        end
        if (c_ready) begin
            c_last_reg <= b_last_reg;
            c_col_reg  <= b_col_reg;
            c_row_reg  <= b_row_reg;
        end
    end

    // window sums over the taps whose column lies on the output row
    always_comb begin
        logic tap_ok;
        c_cv = (COLN_W + 1)'(c_col_reg) + (COLN_W + 1)'(h_reg);
        for (int o = 0; o < ORIENT; o++) begin
            c_sum[o] = '0;
        end
        for (int k = 0; k < MAX_SPAN; k++) begin
            tap_ok = ((COLN_W + 1)'(k) <= ((COLN_W + 1)'(h_reg) << 1))
                     && (c_cv >= (COLN_W + 1)'(k))
                     && ((c_cv - (COLN_W + 1)'(k)) < {1'b0, w_reg});
            for (int o = 0; o < ORIENT; o++) begin
                if (tap_ok) begin
                    c_sum[o] = c_sum[o] + WCNT_W'(taps_reg[k].vcol[o]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready) begin
            d_sum_reg    <= c_sum;
            d_centre_reg <= taps_reg[SLOT_W'(h_reg)].centre;
            d_last_reg   <= c_last_reg;
            d_col_reg    <= c_col_reg;
            d_row_reg    <= c_row_reg;
        end
    end

    always_comb begin
        wcnt_t                    maxc;
        logic [$clog2(ORIENT)-1:0] best;
        maxc = '0;
        best = '0;
        for (int o = 0; o < ORIENT; o++) begin
            if (d_sum_reg[o] > maxc) begin
                maxc = d_sum_reg[o];
                best = ($clog2(ORIENT))'(o);
            end
        end
        if (!mode_reg) begin
            for (int o = 0; o < ORIENT; o++) begin
                d_res[o] = (d_sum_reg[o] != '0);
            end
        end else if ((maxc > WCNT_W'(1)) && (d_centre_reg != '0)) begin
            d_res = pix_t'(1) << best;
        end else begin
            d_res = d_centre_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_pix_reg  <= d_res;
            m_row_reg  <= POS_W'(d_row_reg);
            m_col_reg  <= POS_W'(d_col_reg);
            m_last_reg <= d_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_col_reg, m_row_reg, m_pix_reg};
    assign m_tlast  = m_last_reg;

    a_push_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_idx_reg != '0) |-> (push_idx_reg == (out_idx_reg + RAS_W'(h_reg))))
        else $error("push pointer out of step with output pointer");

    a_arrived_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_pend_reg |-> (arrived_reg <= total_reg))
        else $error("more pixels stored than the frame holds");

    a_out_col: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_pend_reg |-> (COLN_W'(out_col_reg) < w_reg))
        else $error("output column beyond row width");

endmodule
